FILE: hdl/ipg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipg_pkg
// Shared types and constants of the image pyramid gradient block.
// ----------------------------------------------------------------------------
package ipg_pkg;

  // Stream and field widths
  localparam int PIX_W     = 8;
  localparam int LEVEL_W   = 3;
  localparam int COORD_W   = 11;
  localparam int INTEN_W   = 16;
  localparam int GRAD_W    = 17;
  localparam int ROOT_W    = 17;
  localparam int FIELD_W   = LEVEL_W + 2 * COORD_W + INTEN_W + 3 * GRAD_W;
  localparam int TDATA_W   = ((FIELD_W + 7) / 8) * 8;

  // Squared magnitude fits below 2^33
  localparam int SQ_W      = 33;

  // Configuration port
  localparam int CFG_W     = 12;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic lvl_start;
    logic cap_above;
    logic cap_right;
    logic commit;
    logic sq_x;
    logic sq_sum;
    logic root_start;
    logic push_a;
    logic push_b;
    logic next_level;
    logic flush;
  } ipg_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;
    logic has_a;
    logic has_b;
    logic go_next;
    logic out_free;
    logic staged_valid;
    logic root_busy;
  } ipg_status_t;

endpackage
`default_nettype wire

FILE: hdl/image_pyramid_gradient.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// image_pyramid_gradient
// Streaming 2x2 box-filter pyramid with gradients: central difference across, forward difference down.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ stream in raster order, one 8-bit grey value per
// transaction. Every pixel of every level leaves on the m_ stream with its
// level, position, intensity, gradients and gradient norm; m_tlast marks the
// final result of an input pixel and m_tuser the final result of a frame.
// Frame size is set through the APB registers (width at 0x0, height at 0x4);
// a write restarts the frame.
// One input pixel at a time is processed. Each level visited takes a level setup,
// two neighbor reads, the commit and a step; each result with a row above adds
// squaring and the bit-serial square root, and each result is then handed over.
// Accepting and closing a pixel are steps of their own.
// Results are held in a staging register and an output register, so a stalled
// receiver only stops the sequencer when both are full. Reset restores the
// default 640x480 frame and starts a new frame; the line stores need no clear.
// ----------------------------------------------------------------------------
module image_pyramid_gradient
  import ipg_pkg::*;
#(
  parameter int LEVELS     = 5,
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  // pixel[7:0]
  input  wire logic [PIX_W-1:0]   s_tdata,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  // level[2:0] column[13:3] row[24:14] intensity[40:25] grad_x[57:41]
  // grad_y[74:58] grad_norm[91:75], zero fill above
  output logic      [TDATA_W-1:0] m_tdata,
  output logic                    m_tlast,
  // frame_end[0]
  output logic                    m_tuser,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [APB_AW-1:0]  paddr,
  input  wire logic [APB_DW-1:0]  pwdata,
  output logic      [APB_DW-1:0]  prdata,
  output logic                    pready
);

  ipg_cmd_t    cmd;
  ipg_status_t st;

  assign pready = 1'b1;

  ipg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .st       (st),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  ipg_datapath #(
    .LEVELS     (LEVELS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
  );

`ifndef ASSERT_OFF
  // Drop ready while a pixel is in work
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while previous pixel in work");

  // Frame end only on the final result of a pixel
  a_frame_end_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("frame end without last");

  // At most one handover per cycle
  a_one_handover: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.push_a, cmd.push_b, cmd.flush}))
    else $error("conflicting handovers");

  // Never stage a gradient result before the root settles
  a_root_settled: assert property (@(posedge clk) disable iff (rst)
    cmd.push_a |-> !st.root_busy)
    else $error("result staged while root busy");
`endif

endmodule
`default_nettype wire

FILE: hdl/ipg_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipg_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ipg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/ipg_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipg_isqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ipg_isqrt
  import ipg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [SQ_W-1:0]   radicand,
  output logic      [ROOT_W-1:0] root,
  output logic                   busy
);

  logic [SQ_W-1:0] rem;
  logic [SQ_W:0]   res;
  logic [SQ_W-1:0] bitv;
  logic [SQ_W:0]   trial;

  assign trial = res + {1'b0, bitv};
  assign busy  = (bitv != '0);
  assign root  = ROOT_W'(res);

  // Walk the test bit down by two positions each cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      bitv <= '0;
    end else if (start) begin
      bitv <= {1'b1, {(SQ_W-1){1'b0}}};
    end else if (busy) begin
      bitv <= bitv >> 2;
    end
  end

  // Remainder and partial root
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= radicand;
      res <= '0;
    end else if (busy) begin
      if ({1'b0, rem} >= trial) begin
        rem <= SQ_W'({1'b0, rem} - trial);
        res <= (res >> 1) + {1'b0, bitv};
      end else begin
        res <= res >> 1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/ipg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipg_datapath
// Line stores, pair sums, level counters, gradients, root unit, result
// staging and output register, plus the configuration registers.
// ----------------------------------------------------------------------------
module ipg_datapath
  import ipg_pkg::*;
#(
  parameter int LEVELS     = 5,
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ipg_cmd_t           cmd,
  output ipg_status_t             st,
  input  wire logic [PIX_W-1:0]   s_tdata,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic      [TDATA_W-1:0] m_tdata,
  output logic                    m_tlast,
  output logic                    m_tuser,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [APB_AW-1:0]  paddr,
  input  wire logic [APB_DW-1:0]  pwdata,
  output logic      [APB_DW-1:0]  prdata
);

  localparam int LW         = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CW         = $clog2(MAX_WIDTH + 1);
  localparam int RW         = $clog2(MAX_HEIGHT + 1);
  localparam int LINE_DEPTH = 4 * MAX_WIDTH;
  localparam int LAW        = $clog2(LINE_DEPTH);
  localparam int PAW        = $clog2(MAX_WIDTH);
  localparam int PSUM_W     = INTEN_W + 1;

  // Start of a level's two lines in the line store
  function automatic logic [LAW-1:0] line_base(input logic [LW-1:0] l);
    int b;
    b = 0;
    for (int k = 0; k < LEVELS; k++) begin
      if (k < int'(l)) b += 2 * (MAX_WIDTH >> k);
    end
    return LAW'(b);
  endfunction

  // Start of the pair sums of the level above l
  function automatic logic [PAW-1:0] pair_base(input logic [LW-1:0] l);
    int b;
    b = 0;
    for (int k = 1; k < LEVELS; k++) begin
      if (k <= int'(l)) b += (MAX_WIDTH >> k);
    end
    return PAW'(b);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic             cfg_wr;
  logic [CW-1:0]    w_eff;
  logic [RW-1:0]    h_eff;

  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FRAME_HEIGHT) begin
        frame_height <= pwdata[CFG_W-1:0];
      end else begin
        frame_width <= pwdata[CFG_W-1:0];
      end
    end
  end

  assign prdata = {{(APB_DW-CFG_W){1'b0}},
                   (paddr[2] == REG_FRAME_HEIGHT) ? frame_height : frame_width};

  // Clamp the frame size to the supported range
  always_comb begin
    if (frame_width < CFG_W'(2)) begin
      w_eff = CW'(2);
    end else if (int'(frame_width) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(frame_width);
    end
    if (frame_height < CFG_W'(2)) begin
      h_eff = RW'(2);
    end else if (int'(frame_height) > MAX_HEIGHT) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(frame_height);
    end
  end

  // --------------------------------------------------------------------------
  // Per-input and per-level state
  // --------------------------------------------------------------------------
  logic [LW-1:0]      lv;
  logic [INTEN_W-1:0] val;
  logic               frame_done;
  logic [CW-1:0]      col_cnt [LEVELS];
  logic [RW-1:0]      row_cnt [LEVELS];
  logic [INTEN_W-1:0] pend    [LEVELS];
  logic               restart;

  // Position of the current level, looked up at level start
  logic [CW-1:0]  q_c;
  logic [RW-1:0]  p_c;
  logic [CW-1:0]  cols_c;
  logic [RW-1:0]  rows_c;
  logic [LAW-1:0] lb_c;
  logic [LAW-1:0] stride_c;
  logic [LAW-1:0] cur_c;
  logic [LAW-1:0] oth_c;
  logic [PAW-1:0] pidx_c;

  assign q_c      = col_cnt[lv];
  assign p_c      = row_cnt[lv];
  assign cols_c   = w_eff >> lv;
  assign rows_c   = h_eff >> lv;
  assign lb_c     = line_base(lv);
  assign stride_c = LAW'(MAX_WIDTH >> lv);
  assign cur_c    = lb_c + (p_c[0] ? stride_c : '0) + LAW'(q_c);
  assign oth_c    = lb_c + (p_c[0] ? '0 : stride_c) + LAW'(q_c);
  assign pidx_c   = pair_base(lv) + PAW'(q_c >> 1);

  // Latched level context
  logic [CW-1:0]  q_r;
  logic [RW-1:0]  p_r;
  logic [CW-1:0]  cols_r;
  logic [RW-1:0]  rows_r;
  logic [LAW-1:0] cur_r;
  logic [LAW-1:0] oth_r;
  logic [PAW-1:0] pidx_r;

  always_ff @(posedge clk) begin
    if (cmd.lvl_start) begin
      q_r    <= q_c;
      p_r    <= p_c;
      cols_r <= cols_c;
      rows_r <= rows_c;
      cur_r  <= cur_c;
      oth_r  <= oth_c;
      pidx_r <= pidx_c;
    end
  end

  // --------------------------------------------------------------------------
  // Line store and pair-sum store
  // --------------------------------------------------------------------------
  logic [LAW-1:0]     line_raddr;
  logic [INTEN_W-1:0] line_rdata;
  logic [PAW-1:0]     pair_raddr;
  logic [PSUM_W-1:0]  pair_rdata;
  logic               pair_we;

  assign line_raddr = cmd.lvl_start ? oth_c
                    : (cmd.cap_above ? oth_r + LAW'(1) : oth_r - LAW'(1));
  assign pair_raddr = cmd.lvl_start ? pidx_c : pidx_r;

  ipg_ram #(
    .WIDTH (INTEN_W),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (cur_r),
    .wdata (val),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  // Neighbors of the pixel above
  logic [INTEN_W-1:0] above_r;
  logic [INTEN_W-1:0] right_r;

  always_ff @(posedge clk) begin
    if (cmd.cap_above) above_r <= line_rdata;
    if (cmd.cap_right) right_r <= line_rdata;
  end

  // --------------------------------------------------------------------------
  // Commit: gradients, coarser-level sums, counters
  // --------------------------------------------------------------------------
  logic                     grad_ok;
  logic                     has_coarser;
  logic                     pair_ok;
  logic [PSUM_W-1:0]        psum;
  logic [PSUM_W:0]          quad_sum;
  logic signed [GRAD_W-1:0] gx_c;
  logic signed [GRAD_W-1:0] gy_c;
  logic signed [GRAD_W-1:0] gx_r;
  logic signed [GRAD_W-1:0] gy_r;
  logic [INTEN_W-1:0]       nval_r;
  logic                     go_next_r;
  logic                     col_end;

  assign grad_ok     = (q_r != '0) && ((q_r + 1'b1) < cols_r) && (p_r >= RW'(2));
  assign has_coarser = int'(lv) < (LEVELS - 1);
  assign pair_ok     = has_coarser && q_r[0] && ((q_r >> 1) < (cols_r >> 1))
                       && ((p_r >> 1) < (rows_r >> 1));
  assign psum        = {1'b0, pend[lv]} + {1'b0, val};
  assign quad_sum    = {1'b0, pair_rdata} + {1'b0, psum};
  assign pair_we     = cmd.commit && pair_ok && !p_r[0];
  assign gx_c        = $signed({1'b0, right_r}) - $signed({1'b0, line_rdata});
  assign gy_c        = $signed({1'b0, val}) - $signed({1'b0, above_r});
  assign col_end     = (CW'(q_r + 1'b1) == cols_r);

  ipg_ram #(
    .WIDTH (PSUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_pair_ram (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pidx_r),
    .wdata (psum),
    .raddr (pair_raddr),
    .rdata (pair_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      gx_r   <= grad_ok ? gx_c : '0;
      gy_r   <= grad_ok ? gy_c : '0;
      nval_r <= quad_sum[PSUM_W:2];
    end
  end

  // Input item and level walk
  always_ff @(posedge clk) begin
    if (rst) begin
      lv         <= '0;
      frame_done <= 1'b0;
      go_next_r  <= 1'b0;
    end else if (cmd.accept) begin
      lv         <= '0;
      frame_done <= 1'b0;
      go_next_r  <= 1'b0;
    end else if (cmd.commit) begin
      go_next_r <= pair_ok && p_r[0];
      if (lv == '0 && col_end && (RW'(p_r + 1'b1) == rows_r)) begin
        frame_done <= 1'b1;
      end
    end else if (cmd.next_level) begin
      lv <= lv + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      val <= {s_tdata, {(INTEN_W-PIX_W){1'b0}}};
    end else if (cmd.next_level) begin
      val <= nval_r;
    end
  end

  // Restart the frame at its end and on any register write
  assign restart = cfg_wr || (cmd.flush && frame_done);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      for (int i = 0; i < LEVELS; i++) begin
        col_cnt[i] <= '0;
        row_cnt[i] <= '0;
        pend[i]    <= '0;
      end
    end else if (cmd.commit) begin
      if (col_end) begin
        col_cnt[lv] <= '0;
        row_cnt[lv] <= RW'(p_r + 1'b1);
      end else begin
        col_cnt[lv] <= CW'(q_r + 1'b1);
      end
      if (has_coarser && !q_r[0]) begin
        pend[lv] <= val;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Squared magnitude and root
  // --------------------------------------------------------------------------
  logic signed [2*GRAD_W-1:0] gx_sq;
  logic signed [2*GRAD_W-1:0] gy_sq;
  logic [SQ_W-1:0]            sqx_r;
  logic [SQ_W-1:0]            sq_r;
  logic [ROOT_W-1:0]          root;
  logic                       root_busy;

  assign gx_sq = gx_r * gx_r;
  assign gy_sq = gy_r * gy_r;

  always_ff @(posedge clk) begin
    if (cmd.sq_x)   sqx_r <= SQ_W'(gx_sq);
    if (cmd.sq_sum) sq_r  <= sqx_r + SQ_W'(gy_sq);
  end

  ipg_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.root_start),
    .radicand (sq_r),
    .root     (root),
    .busy     (root_busy)
  );

  // --------------------------------------------------------------------------
  // Result staging and output register
  // --------------------------------------------------------------------------
  logic                     push;
  logic                     staged_valid;
  logic [LEVEL_W-1:0]       stg_level;
  logic [COORD_W-1:0]       stg_col;
  logic [COORD_W-1:0]       stg_row;
  logic [INTEN_W-1:0]       stg_int;
  logic signed [GRAD_W-1:0] stg_gx;
  logic signed [GRAD_W-1:0] stg_gy;
  logic [ROOT_W-1:0]        stg_norm;
  logic [LEVEL_W-1:0]       o_level;
  logic [COORD_W-1:0]       o_col;
  logic [COORD_W-1:0]       o_row;
  logic [INTEN_W-1:0]       o_int;
  logic signed [GRAD_W-1:0] o_gx;
  logic signed [GRAD_W-1:0] o_gy;
  logic [ROOT_W-1:0]        o_norm;
  logic                     load_out;

  assign push     = cmd.push_a || cmd.push_b;
  assign load_out = staged_valid && (push || cmd.flush);

  // Track staged and output occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      staged_valid <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (push) begin
        staged_valid <= 1'b1;
      end else if (cmd.flush) begin
        staged_valid <= 1'b0;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Hold the newest result until the next one shows whether it is final
  always_ff @(posedge clk) begin
    if (push) begin
      stg_level <= LEVEL_W'(lv);
      stg_col   <= COORD_W'(q_r);
      stg_row   <= cmd.push_a ? COORD_W'(p_r - 1'b1) : COORD_W'(p_r);
      stg_int   <= cmd.push_a ? above_r : val;
      stg_gx    <= cmd.push_a ? gx_r : '0;
      stg_gy    <= cmd.push_a ? gy_r : '0;
      stg_norm  <= cmd.push_a ? root : '0;
    end
    if (load_out) begin
      o_level <= stg_level;
      o_col   <= stg_col;
      o_row   <= stg_row;
      o_int   <= stg_int;
      o_gx    <= stg_gx;
      o_gy    <= stg_gy;
      o_norm  <= stg_norm;
      m_tlast <= cmd.flush;
      m_tuser <= cmd.flush && frame_done;
    end
  end

  assign m_tdata = {{(TDATA_W-FIELD_W){1'b0}}, o_norm, o_gy, o_gx, o_int,
                    o_row, o_col, o_level};

  // Status to the controller
  assign st.empty        = (q_c >= cols_c) || (p_c >= rows_c);
  assign st.has_a        = (p_r != '0);
  assign st.has_b        = (RW'(p_r + 1'b1) == rows_r);
  assign st.go_next      = go_next_r;
  assign st.out_free     = !m_tvalid || m_tready;
  assign st.staged_valid = staged_valid;
  assign st.root_busy    = root_busy;

endmodule
`default_nettype wire

FILE: hdl/ipg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipg_ctrl
// Sequencer: walks one input pixel through the pyramid levels and hands
// each result to the staging register.
// ----------------------------------------------------------------------------
module ipg_ctrl
  import ipg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ipg_status_t st,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  output ipg_cmd_t         cmd
);

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_LVL   = 13'b0000000000010,
    ST_RD1   = 13'b0000000000100,
    ST_RD2   = 13'b0000000001000,
    ST_RD3   = 13'b0000000010000,
    ST_SQX   = 13'b0000000100000,
    ST_SQY   = 13'b0000001000000,
    ST_ROOTS = 13'b0000010000000,
    ST_ROOTW = 13'b0000100000000,
    ST_PUSHA = 13'b0001000000000,
    ST_PUSHB = 13'b0010000000000,
    ST_STEP  = 13'b0100000000000,
    ST_FLUSH = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   can_push;

  assign s_tready = (state == ST_IDLE);
  assign can_push = st.out_free || !st.staged_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = ST_LVL;
        end
      end
      ST_LVL: begin
        cmd.lvl_start = 1'b1;
        state_next    = st.empty ? ST_FLUSH : ST_RD1;
      end
      ST_RD1: begin
        cmd.cap_above = 1'b1;
        state_next    = ST_RD2;
      end
      ST_RD2: begin
        cmd.cap_right = 1'b1;
        state_next    = ST_RD3;
      end
      ST_RD3: begin
        cmd.commit = 1'b1;
        if (st.has_a) begin
          state_next = ST_SQX;
        end else if (st.has_b) begin
          state_next = ST_PUSHB;
        end else begin
          state_next = ST_STEP;
        end
      end
      ST_SQX: begin
        cmd.sq_x   = 1'b1;
        state_next = ST_SQY;
      end
      ST_SQY: begin
        cmd.sq_sum = 1'b1;
        state_next = ST_ROOTS;
      end
      ST_ROOTS: begin
        cmd.root_start = 1'b1;
        state_next     = ST_ROOTW;
      end
      ST_ROOTW: begin
        if (!st.root_busy) state_next = ST_PUSHA;
      end
      ST_PUSHA: begin
        if (can_push) begin
          cmd.push_a = 1'b1;
          state_next = st.has_b ? ST_PUSHB : ST_STEP;
        end
      end
      ST_PUSHB: begin
        if (can_push) begin
          cmd.push_b = 1'b1;
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (st.go_next) begin
          cmd.next_level = 1'b1;
          state_next     = ST_LVL;
        end else begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (can_push) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
